// ===== sv/spdn_pkg.sv =====
package spdn_pkg;

	// Table size default
	localparam int TableSlotsDefault = 16;

	// Depth of the queue between front and back (power of two)
	localparam int QueueDepth = 4;

	// Header classification constants
	localparam logic [15:0] EthertypeIp = 16'h0800;
	localparam logic [7:0]  IpprotoTcp  = 8'd6;
	localparam logic [7:0]  IpprotoUdp  = 8'd17;

	// Item kinds
	localparam logic FuncXlate = 1'b0;
	localparam logic FuncLoad  = 1'b1;

	// Classified header as it travels from front to back
	typedef struct packed {
		logic        hit;
		logic [15:0] orig_port;
		logic [31:0] orig_addr;
		logic [15:0] map_port;
		logic [31:0] new_addr;
	} spdn_item_t;

endpackage

// ===== sv/spdn_front.sv =====
module spdn_front #(
	parameter int TableSlots = spdn_pkg::TableSlotsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                func,
	input  logic [15:0]         ether_kind,
	input  logic [7:0]          ip_protocol,
	input  logic [15:0]         dest_port,
	input  logic [31:0]         dest_addr,
	input  logic [3:0]          slot_index,
	input  logic                slot_enable,
	input  logic [15:0]         slot_match_port,
	input  logic [31:0]         slot_new_addr,
	input  logic [15:0]         slot_new_port,
	input  logic                q_full,
	output logic                q_push,
	output spdn_pkg::spdn_item_t q_item
);

	localparam int IdxW = (TableSlots > 1) ? $clog2(TableSlots) : 1;

	// Slot table: every entry is compared in parallel
	logic [TableSlots-1:0] slot_valid_q;
	logic [15:0]           slot_key_q  [TableSlots];
	logic [31:0]           slot_addr_q [TableSlots];
	logic [15:0]           slot_port_q [TableSlots];

	logic                 valid_s1;
	spdn_pkg::spdn_item_t item_s1;

	logic                 accept;
	logic                 s1_ready;
	logic [IdxW+3:0]      idx_ext;
	logic [IdxW-1:0]      wr_idx;
	logic                 wr_in_range;
	logic                 is_l4;
	spdn_pkg::spdn_item_t item_d;

	// Handshake
	assign s1_ready = !valid_s1 || !q_full;
	assign full     = !s1_ready;
	assign accept   = push && s1_ready;
	assign q_push   = valid_s1 && !q_full;
	assign q_item   = item_s1;

	// Load address decode; indexes past the table are dropped
	assign idx_ext     = {{IdxW{1'b0}}, slot_index};
	assign wr_in_range = idx_ext < (IdxW + 4)'(TableSlots);
	assign wr_idx      = idx_ext[IdxW-1:0];

	// Header classification and lowest-slot match
	assign is_l4 = (ether_kind == spdn_pkg::EthertypeIp) &&
		((ip_protocol == spdn_pkg::IpprotoTcp) || (ip_protocol == spdn_pkg::IpprotoUdp));

	always_comb begin
		item_d.hit       = 1'b0;
		item_d.orig_port = dest_port;
		item_d.orig_addr = dest_addr;
		item_d.map_port  = dest_port;
		item_d.new_addr  = dest_addr;
		// walk downward so the lowest matching slot is the last to win
		for (int i = TableSlots - 1; i >= 0; i--) begin
			if (is_l4 && slot_valid_q[i] && (slot_key_q[i] == dest_port)) begin
				item_d.hit      = 1'b1;
				item_d.map_port = slot_port_q[i];
				item_d.new_addr = slot_addr_q[i];
			end
		end
	end

	// Valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (accept && (func == spdn_pkg::FuncLoad) && wr_in_range) begin
			slot_valid_q[wr_idx] <= slot_enable;
		end
	end

	// Slot contents
	always_ff @(posedge clk) begin
		if (accept && (func == spdn_pkg::FuncLoad) && wr_in_range) begin
			slot_key_q[wr_idx]  <= slot_match_port;
			slot_addr_q[wr_idx] <= slot_new_addr;
			slot_port_q[wr_idx] <= slot_new_port;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= accept && (func == spdn_pkg::FuncXlate);
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept && (func == spdn_pkg::FuncXlate)) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ===== sv/spdn_queue.sv =====
module spdn_queue #(
	parameter int Depth = spdn_pkg::QueueDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  spdn_pkg::spdn_item_t wr_item,
	output logic                 q_full,
	input  logic                 rd_en,
	output spdn_pkg::spdn_item_t rd_item,
	output logic                 q_empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	spdn_pkg::spdn_item_t mem_q [Depth];
	logic [PtrW-1:0]      wr_ptr_q;
	logic [PtrW-1:0]      rd_ptr_q;
	logic [CntW-1:0]      count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign q_full  = (count_q == CntW'(Depth));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_item = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/spdn_back.sv =====
module spdn_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  spdn_pkg::spdn_item_t q_item,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [15:0]          xlat_port,
	output logic [31:0]          out_addr,
	output logic                 translated
);

	logic        out_valid_q;
	logic [15:0] xlat_port_q;
	logic [31:0] out_addr_q;
	logic        translated_q;
	logic        take;

	// Pull from the queue whenever the output register is free or drains
	assign take  = !q_empty && (!out_valid_q || pop);
	assign q_pop = take;
	assign empty = !out_valid_q;

	assign xlat_port  = xlat_port_q;
	assign out_addr   = out_addr_q;
	assign translated = translated_q;

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q <= !q_empty;
		end
	end

	// Apply the rewrite
	always_ff @(posedge clk) begin
		if (take) begin
			xlat_port_q  <= q_item.hit ? q_item.map_port : q_item.orig_port;
			out_addr_q   <= q_item.hit ? q_item.new_addr : q_item.orig_addr;
			translated_q <= q_item.hit;
		end
	end

endmodule

// ===== sv/static_port_dnat_rewrite.sv =====
// Static destination NAT (port forwarding).
// Input queue side: push / full. An item is taken on a clock edge with push
// high and full low. func selects a header request (translate) or a load
// request that writes one table slot: valid mark, match port, new address
// and new port. Load requests give no result; a load with an index past the
// table is dropped.
// Result queue side: empty / pop. The oldest result sits on xlat_port,
// out_addr and translated while empty is low; pop takes it.
// A TCP or UDP IPv4 header whose port matches a valid slot is rewritten from
// the lowest matching slot; anything else passes through.
// A header passes the stage register, the queue and the result register before
// it is shown. One request per cycle is taken while full stays low; the
// slot compare, priority pick and stage register set that figure.
// A load takes effect for every header taken after it.
// When pop stays low the result holds; the result register, a four-entry
// queue and the front stage fill up, and full rises only when all are used.
// Reset (arst_n low) clears all valid marks and empties every stage.
module static_port_dnat_rewrite #(
	parameter int TableSlots = spdn_pkg::TableSlotsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        func,
	input  logic [15:0] ether_kind,
	input  logic [7:0]  ip_protocol,
	input  logic [15:0] dest_port,
	input  logic [31:0] dest_addr,
	input  logic [3:0]  slot_index,
	input  logic        slot_enable,
	input  logic [15:0] slot_match_port,
	input  logic [31:0] slot_new_addr,
	input  logic [15:0] slot_new_port,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] xlat_port,
	output logic [31:0] out_addr,
	output logic        translated
);

	logic                 q_full;
	logic                 q_push;
	logic                 q_empty;
	logic                 q_pop;
	spdn_pkg::spdn_item_t front_item;
	spdn_pkg::spdn_item_t back_item;

	// Table and classification
	spdn_front #(
		.TableSlots(TableSlots)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.func            (func),
		.ether_kind      (ether_kind),
		.ip_protocol     (ip_protocol),
		.dest_port       (dest_port),
		.dest_addr       (dest_addr),
		.slot_index      (slot_index),
		.slot_enable     (slot_enable),
		.slot_match_port (slot_match_port),
		.slot_new_addr   (slot_new_addr),
		.slot_new_port   (slot_new_port),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_item          (front_item)
	);

	// Decoupling queue
	spdn_queue #(
		.Depth(spdn_pkg::QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (front_item),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_item (back_item),
		.q_empty (q_empty)
	);

	// Rewrite and result register
	spdn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_item     (back_item),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.xlat_port  (xlat_port),
		.out_addr   (out_addr),
		.translated (translated)
	);

endmodule

// ===== sv/spdn_checker.sv =====
module spdn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [15:0] xlat_port,
	input logic [31:0] out_addr,
	input logic        translated
);

	// A waiting result that is not taken stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(xlat_port) && $stable(out_addr) &&
			$stable(translated)))
		else $error("spdn: waiting result changed before pop");

	// Back pressure reaches the input only once the result side holds a result
	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("spdn: full while no result is waiting");

	// In reset nothing is shown and nothing is blocked
	assert property (@(posedge clk)
		!arst_n |=> (empty && !full))
		else $error("spdn: stage not cleared during reset");

	// Full rises only right after a waiting result was left untaken
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(!empty && !pop))
		else $error("spdn: full rose while results were drained");

endmodule

bind static_port_dnat_rewrite spdn_checker u_spdn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.xlat_port  (xlat_port),
	.out_addr   (out_addr),
	.translated (translated)
);

// ===== test/static_port_dnat_rewrite_test.sv =====
`timescale 1ns / 100ps

module static_port_dnat_rewrite_test;

	localparam int CycleLimit = 200000;
	localparam int RandomItems = 1650;
	localparam int PoolSize = 8;

	// One request as presented on the input side
	typedef struct packed {
		logic        func;
		logic [15:0] ether_kind;
		logic [7:0]  ip_protocol;
		logic [15:0] dest_port;
		logic [31:0] dest_addr;
		logic [3:0]  slot_index;
		logic        slot_enable;
		logic [15:0] slot_match_port;
		logic [31:0] slot_new_addr;
		logic [15:0] slot_new_port;
	} nat_req_t;

	// One translated header as seen on the result side
	typedef struct packed {
		logic [15:0] port;
		logic [31:0] addr;
		logic        hit;
	} xlate_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	nat_req_t    cur_req = '0;
	logic        full;
	logic        empty;
	logic [15:0] xlat_port;
	logic [31:0] out_addr;
	logic        translated;

	// Forwarding table as the block should hold it
	logic        fwd_valid [spdn_pkg::TableSlotsDefault];
	logic [15:0] fwd_key   [spdn_pkg::TableSlotsDefault];
	logic [31:0] fwd_addr  [spdn_pkg::TableSlotsDefault];
	logic [15:0] fwd_port  [spdn_pkg::TableSlotsDefault];

	nat_req_t    req_pending_q[$];
	xlate_res_t  xlate_expect_q[$];
	logic [15:0] port_pool [PoolSize];

	int err_count = 0;
	int cycle_count = 0;
	int header_count = 0;
	int load_count = 0;
	int rewrite_count = 0;
	int result_count = 0;
	int burst_left = 1;
	int gap_left = 0;
	int pop_mode = 0;
	int mode_left = 0;

	static_port_dnat_rewrite i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.func           (cur_req.func),
		.ether_kind     (cur_req.ether_kind),
		.ip_protocol    (cur_req.ip_protocol),
		.dest_port      (cur_req.dest_port),
		.dest_addr      (cur_req.dest_addr),
		.slot_index     (cur_req.slot_index),
		.slot_enable    (cur_req.slot_enable),
		.slot_match_port(cur_req.slot_match_port),
		.slot_new_addr  (cur_req.slot_new_addr),
		.slot_new_port  (cur_req.slot_new_port),
		.empty          (empty),
		.pop            (pop),
		.xlat_port      (xlat_port),
		.out_addr       (out_addr),
		.translated     (translated)
	);

	always #5 clk = ~clk;

	// Translation of one header against the current table
	function automatic xlate_res_t translate_header(nat_req_t r);
		xlate_res_t res;
		res.port = r.dest_port;
		res.addr = r.dest_addr;
		res.hit  = 1'b0;
		if (r.ether_kind == spdn_pkg::EthertypeIp &&
				(r.ip_protocol == spdn_pkg::IpprotoTcp ||
				r.ip_protocol == spdn_pkg::IpprotoUdp)) begin
			for (int i = spdn_pkg::TableSlotsDefault - 1; i >= 0; i--) begin
				// scan downward so the lowest matching slot is the last written
				if (fwd_valid[i] && fwd_key[i] == r.dest_port) begin
					res.port = fwd_port[i];
					res.addr = fwd_addr[i];
					res.hit  = 1'b1;
				end
			end
		end
		return res;
	endfunction

	// Accepted request: update the table or queue the expected result
	task automatic apply_request(nat_req_t r);
		xlate_res_t res;
		if (r.func == spdn_pkg::FuncLoad) begin
			fwd_valid[r.slot_index] = r.slot_enable;
			fwd_key[r.slot_index]   = r.slot_match_port;
			fwd_addr[r.slot_index]  = r.slot_new_addr;
			fwd_port[r.slot_index]  = r.slot_new_port;
			load_count++;
		end else begin
			res = translate_header(r);
			xlate_expect_q.push_back(res);
			header_count++;
			if (res.hit)
				rewrite_count++;
		end
	endtask

	function automatic nat_req_t noise_request();
		nat_req_t r;
		logic [159:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
		r = bits[$bits(nat_req_t)-1:0];
		return r;
	endfunction

	function automatic nat_req_t mk_load(logic [3:0] idx, logic en, logic [15:0] key,
			logic [31:0] addr, logic [15:0] port);
		nat_req_t r;
		r = noise_request();
		r.func            = spdn_pkg::FuncLoad;
		r.slot_index      = idx;
		r.slot_enable     = en;
		r.slot_match_port = key;
		r.slot_new_addr   = addr;
		r.slot_new_port   = port;
		return r;
	endfunction

	function automatic nat_req_t mk_header(logic [15:0] ether, logic [7:0] proto,
			logic [15:0] port, logic [31:0] addr);
		nat_req_t r;
		r = noise_request();
		r.func        = spdn_pkg::FuncXlate;
		r.ether_kind  = ether;
		r.ip_protocol = proto;
		r.dest_port   = port;
		r.dest_addr   = addr;
		return r;
	endfunction

	// Mostly well-formed TCP/UDP headers on pooled ports, some loads, some noise
	function automatic nat_req_t random_request();
		nat_req_t r;
		int pick;
		logic [15:0] port;
		logic [7:0] proto;
		pick  = $urandom_range(99, 0);
		port  = ($urandom_range(3, 0) != 0) ? port_pool[$urandom_range(PoolSize - 1, 0)]
			: 16'($urandom);
		proto = $urandom_range(1, 0) ? spdn_pkg::IpprotoTcp : spdn_pkg::IpprotoUdp;
		if (pick < 12)
			r = mk_load(4'($urandom_range(15, 0)), ($urandom_range(4, 0) != 0), port,
				$urandom, 16'($urandom));
		else if (pick < 72)
			r = mk_header(spdn_pkg::EthertypeIp, proto, port, $urandom);
		else if (pick < 80)
			r = mk_header(spdn_pkg::EthertypeIp, 8'($urandom), port, $urandom);
		else if (pick < 88)
			r = mk_header(spdn_pkg::EthertypeIp ^ (16'h1 << $urandom_range(15, 0)), proto,
				port, $urandom);
		else begin
			r = noise_request();
			r.func = spdn_pkg::FuncXlate;
		end
		return r;
	endfunction

	// Request driver: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push    <= 1'b0;
			cur_req <= '0;
		end else begin
			if (push && !full)
				apply_request(cur_req);
			if (!push || !full) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (req_pending_q.size() > 0) begin
					cur_req <= req_pending_q.pop_front();
					push    <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(9, 0) == 0) ? 200 : $urandom_range(48, 1);
						gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each popped result, then pick the next pop
	always @(posedge clk or negedge arst_n) begin
		xlate_res_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				result_count++;
				if (xlate_expect_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual port %h addr %h hit %b",
						$time, xlat_port, out_addr, translated);
					err_count++;
				end else begin
					want = xlate_expect_q.pop_front();
					if (xlat_port !== want.port) begin
						$display("%0t: xlat_port mismatch: expected %h, actual %h",
							$time, want.port, xlat_port);
						err_count++;
					end
					if (out_addr !== want.addr) begin
						$display("%0t: out_addr mismatch: expected %h, actual %h",
							$time, want.addr, out_addr);
						err_count++;
					end
					if (translated !== want.hit) begin
						$display("%0t: translated mismatch: expected %b, actual %b",
							$time, want.hit, translated);
						err_count++;
					end
				end
			end
			if (mode_left <= 0) begin
				pop_mode  = $urandom_range(2, 0);
				mode_left = $urandom_range(200, 20);
			end
			mode_left--;
			unique case (pop_mode)
				0: begin
					pop <= 1'b1;
				end
				1: begin
					pop <= 1'($urandom_range(1, 0));
				end
				default: begin
					pop <= ($urandom_range(7, 0) == 0);
				end
			endcase
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		port_pool[0] = 16'h0000;
		port_pool[1] = 16'hFFFF;
		for (int i = 2; i < PoolSize; i++)
			port_pool[i] = 16'($urandom);
		for (int i = 0; i < spdn_pkg::TableSlotsDefault; i++)
			fwd_valid[i] = 1'b0;

		// directed: empty table, extremes, priority, disabled slot, non-IP traffic
		req_pending_q.push_back(mk_header(spdn_pkg::EthertypeIp, spdn_pkg::IpprotoTcp,
			16'd80, 32'h0A000001));
		req_pending_q.push_back(mk_load(4'd0, 1'b1, 16'd80, 32'hC0A80001, 16'd8080));
		req_pending_q.push_back(mk_load(4'd15, 1'b1, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF));
		req_pending_q.push_back(mk_load(4'd3, 1'b1, 16'd80, 32'hC0A80003, 16'd8083));
		req_pending_q.push_back(mk_load(4'd5, 1'b0, 16'd443, 32'hC0A80005, 16'd8443));
		req_pending_q.push_back(mk_load(4'd7, 1'b1, 16'h0000, 32'h00000000, 16'h0000));
		req_pending_q.push_back(mk_header(spdn_pkg::EthertypeIp, spdn_pkg::IpprotoTcp,
			16'd80, 32'h00000000));
		req_pending_q.push_back(mk_header(spdn_pkg::EthertypeIp, spdn_pkg::IpprotoUdp,
			16'd80, 32'hFFFFFFFF));
		req_pending_q.push_back(mk_header(spdn_pkg::EthertypeIp, 8'd1, 16'd80, 32'h0A000002));
		req_pending_q.push_back(mk_header(spdn_pkg::EthertypeIp, 8'd255, 16'd80,
			32'h0A000003));
		req_pending_q.push_back(mk_header(16'h86DD, spdn_pkg::IpprotoTcp, 16'd80,
			32'h0A000004));
		req_pending_q.push_back(mk_header(16'h0801, spdn_pkg::IpprotoUdp, 16'd80,
			32'h0A000005));
		req_pending_q.push_back(mk_header(16'hFFFF, spdn_pkg::IpprotoTcp, 16'd80,
			32'h0A000006));
		req_pending_q.push_back(mk_header(spdn_pkg::EthertypeIp, spdn_pkg::IpprotoTcp,
			16'hFFFF, 32'h0A000007));
		req_pending_q.push_back(mk_header(spdn_pkg::EthertypeIp, spdn_pkg::IpprotoUdp,
			16'h0000, 32'h0A000008));
		req_pending_q.push_back(mk_header(spdn_pkg::EthertypeIp, spdn_pkg::IpprotoTcp,
			16'd443, 32'h0A000009));
		req_pending_q.push_back(mk_header(spdn_pkg::EthertypeIp, spdn_pkg::IpprotoUdp,
			16'd22, 32'h0A00000A));
		// disable slot 0: port 80 now falls to slot 3
		req_pending_q.push_back(mk_load(4'd0, 1'b0, 16'd80, 32'h11111111, 16'd1111));
		req_pending_q.push_back(mk_header(spdn_pkg::EthertypeIp, spdn_pkg::IpprotoTcp,
			16'd80, 32'h0A00000B));
		// reload slot 15 to a new key; old key must miss
		req_pending_q.push_back(mk_load(4'd15, 1'b1, 16'd53, 32'h08080808, 16'd5353));
		req_pending_q.push_back(mk_header(spdn_pkg::EthertypeIp, spdn_pkg::IpprotoUdp,
			16'hFFFF, 32'h0A00000C));
		req_pending_q.push_back(mk_header(spdn_pkg::EthertypeIp, spdn_pkg::IpprotoUdp,
			16'd53, 32'h0A00000D));

		for (int i = 0; i < RandomItems; i++)
			req_pending_q.push_back(random_request());

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_pending_q.size() != 0 || push)
			@(posedge clk);
		while (xlate_expect_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d header requests (%0d rewritten) and %0d table loads,",
			header_count, rewrite_count, load_count);
		$display("%0d results checked under bursty input and stalling output", result_count);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", err_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/spdn_pkg.sv
sv/spdn_front.sv
sv/spdn_queue.sv
sv/spdn_back.sv
sv/static_port_dnat_rewrite.sv
sv/spdn_checker.sv
test/static_port_dnat_rewrite_test.sv
